>>> design/ddrm_pkg.sv
// Package for the differential drive ramp mixer.
// Holds field widths and scaling constants shared by the step unit and the top level.
// No dependencies.
`default_nettype none

package ddrm_pkg;

   localparam int TIME_W  = 32;                 // microsecond timestamp
   localparam int VAL_W   = 16;                 // signed fixed point velocity
   localparam int OUT_W   = 18;                 // mixed drive command
   localparam int CFG_W   = 15;                 // acceleration and max speed
   localparam int STEP_W  = 16;                 // per-tick step, saturating
   localparam int PROD_W  = CFG_W + TIME_W;     // acceleration * elapsed
   localparam int REM_W   = 36;                 // holds any unsaturated product
   localparam int MUL_W   = 32;                 // operand width of the shared multiplier

   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_ACCELERATION = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_SPEED    = 8'd1;

   localparam logic [REM_W-1:0]  US_PER_SECOND = 36'd1000000;
   // divide by one million: drop 2^6, then multiply by ceil(2^44 / 15625)
   // and keep the bits from 44 up; exact for any 30-bit dividend
   localparam int                RECIP_SHIFT   = 6;
   localparam int                RECIP_POS     = 44;
   localparam logic [MUL_W-1:0]  RECIP_15625   = 32'd1125899907;
   // any product at or above this gives a quotient past the step limit
   localparam logic [PROD_W-1:0] SAT_LIMIT     = 47'd65536000000;

endpackage : ddrm_pkg

`default_nettype wire

>>> design/ddrm_if.sv
// Channel interfaces of the differential drive ramp mixer: tick input,
// drive result and register write. Depends on ddrm_pkg.
`default_nettype none

interface ddrm_req_if import ddrm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic        [TIME_W-1:0] now_us;
   logic signed [VAL_W-1:0]  goal_velocity;
   logic signed [VAL_W-1:0]  goal_rotation;
   logic signed [VAL_W-1:0]  correction;

   modport source (output valid, now_us, goal_velocity, goal_rotation, correction,
                   input ready);
   modport sink   (input valid, now_us, goal_velocity, goal_rotation, correction,
                   output ready);
endinterface : ddrm_req_if

interface ddrm_rsp_if import ddrm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] left_drive;
   logic signed [OUT_W-1:0] right_drive;

   modport source (output valid, left_drive, right_drive, input ready);
   modport sink   (input valid, left_drive, right_drive, output ready);
endinterface : ddrm_rsp_if

interface ddrm_csr_if import ddrm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface : ddrm_csr_if

`default_nettype wire

>>> design/ddrm_step_unit.sv
// Step unit: multiplies acceleration by elapsed time, then divides by one
// million by a reciprocal multiply on the same shared multiplier.
// Depends on ddrm_pkg.
`default_nettype none

module ddrm_step_unit import ddrm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [CFG_W-1:0]  acceleration,
   input  wire logic [TIME_W-1:0] elapsed,
   output logic                   done,
   output logic [STEP_W-1:0]      step
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCALE = 2'd1;

   logic [1:0]         state_ff, state_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [STEP_W-1:0]  quo_ff, quo_in;
   logic               done_ff, done_in;
   logic [MUL_W-1:0]   mul_a;
   logic [MUL_W-1:0]   mul_b;
   logic [2*MUL_W-1:0] mul_p;

   // the shared multiplier: acceleration * elapsed first, then the scaled
   // product times the reciprocal of 15625
   always_comb begin
      if (state_ff == S_IDLE) begin
         mul_a = elapsed;
         mul_b = MUL_W'(acceleration);
      end else begin
         mul_a = MUL_W'(prod_ff[REM_W-1:RECIP_SHIFT]);
         mul_b = RECIP_15625;
      end
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      done_in  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               prod_in  = mul_p[PROD_W-1:0];
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            if (prod_ff >= SAT_LIMIT) begin
               quo_in = '1;
            end else begin
               quo_in = mul_p[RECIP_POS +: STEP_W];
            end
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
   end

   assign done = done_ff;
   assign step = quo_ff;

endmodule : ddrm_step_unit

`default_nettype wire

>>> design/diff_drive_ramp_mixer_top.sv
// Top level of the differential drive ramp mixer: tick sequencer, ramp,
// mixer, clamp and result register. Depends on ddrm_pkg, ddrm_if.sv and
// ddrm_step_unit.
`default_nettype none

// Slew-rate limited differential drive mixer. Each tick transfer on req_chan
// carries a microsecond timestamp and the goal velocity, goal rotation and
// correction in signed Q8.8. Elapsed time is the timestamp minus the previous
// one, modulo 2^32 (measured from zero after reset). Velocity and rotation
// each move toward their goals by floor(acceleration * elapsed / 1e6),
// held at 65535, without passing the goal; with acceleration zero they take
// their goals at once. One rsp_chan transfer follows per tick with
// left = vel + rot - correction and right = vel - rot - correction, each
// clamped to +/- max_speed unless max_speed is zero. With acceleration
// zero a tick goes from the transfer straight to the ramp, then mix and
// clamp into the result register; otherwise it passes through start,
// acceleration * elapsed on the shared multiplier, reciprocal multiply with
// the saturation check, hand-off, ramp, then mix and clamp.
// A tick waits in mix and clamp only while the result register is still
// full and not being drained.
// req_chan is ready only while no tick is in work; a finished result sits in
// its output register, so the next tick can be taken while it waits.
// Registers on csr_chan (index 0 acceleration, index 1 max_speed, low 15
// data bits used) are always ready and are to be written while idle.
module diff_drive_ramp_mixer_top import ddrm_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   ddrm_req_if.sink   req_chan,
   ddrm_rsp_if.source rsp_chan,
   ddrm_csr_if.sink   csr_chan
);

   localparam logic [2:0] T_IDLE  = 3'd0;
   localparam logic [2:0] T_START = 3'd1;
   localparam logic [2:0] T_WAIT  = 3'd2;
   localparam logic [2:0] T_MOVE  = 3'd3;
   localparam logic [2:0] T_OUT   = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [CFG_W-1:0]        accel_ff, accel_in;
   logic [CFG_W-1:0]        max_speed_ff, max_speed_in;
   logic [TIME_W-1:0]       last_time_ff, last_time_in;
   logic [TIME_W-1:0]       elapsed_ff, elapsed_in;
   logic signed [VAL_W-1:0] cur_vel_ff, cur_vel_in;
   logic signed [VAL_W-1:0] cur_rot_ff, cur_rot_in;
   logic signed [VAL_W-1:0] goal_vel_ff, goal_vel_in;
   logic signed [VAL_W-1:0] goal_rot_ff, goal_rot_in;
   logic signed [VAL_W-1:0] corr_ff, corr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] left_ff, left_in;
   logic signed [OUT_W-1:0] right_ff, right_in;

   logic                    req_xfer;
   logic                    step_start;
   logic                    step_done;
   logic [STEP_W-1:0]       step;
   logic signed [OUT_W-1:0] mix_left;
   logic signed [OUT_W-1:0] mix_right;
   logic                    out_free;

   // move cur toward goal by step, stopping at the goal
   function automatic logic signed [VAL_W-1:0] approach(
      input logic signed [VAL_W-1:0] cur,
      input logic signed [VAL_W-1:0] goal,
      input logic [STEP_W-1:0]       stp
   );
      logic signed [OUT_W-1:0] c;
      logic signed [OUT_W-1:0] g;
      logic signed [OUT_W-1:0] s;
      logic signed [OUT_W-1:0] t;
      c = OUT_W'(cur);
      g = OUT_W'(goal);
      s = $signed({{(OUT_W-STEP_W){1'b0}}, stp});
      if (c < g) begin
         t = c + s;
         if (t > g) t = g;
      end else begin
         t = c - s;
         if (t < g) t = g;
      end
      return t[VAL_W-1:0];
   endfunction

   // clamp to +/- limit, zero limit passes through
   function automatic logic signed [OUT_W-1:0] clamp(
      input logic signed [OUT_W-1:0] v,
      input logic [CFG_W-1:0]        lim
   );
      logic signed [OUT_W-1:0] l;
      logic signed [OUT_W-1:0] r;
      l = $signed({{(OUT_W-CFG_W){1'b0}}, lim});
      r = v;
      if (lim != '0) begin
         if (r > l)  r = l;
         if (r < -l) r = -l;
      end
      return r;
   endfunction

   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == T_IDLE);
   assign csr_chan.ready = 1'b1;

   // the unclamped sums always fit 18 bits
   assign mix_left  = OUT_W'(cur_vel_ff) + OUT_W'(cur_rot_ff) - OUT_W'(corr_ff);
   assign mix_right = OUT_W'(cur_vel_ff) - OUT_W'(cur_rot_ff) - OUT_W'(corr_ff);

   // result register is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign step_start = (state_ff == T_START);

   ddrm_step_unit u_step (
      .clock        (clock),
      .reset        (reset),
      .start        (step_start),
      .acceleration (accel_ff),
      .elapsed      (elapsed_ff),
      .done         (step_done),
      .step         (step)
   );

   // register writes
   always_comb begin
      accel_in     = accel_ff;
      max_speed_in = max_speed_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.addr)
            REG_ACCELERATION: accel_in     = csr_chan.data[CFG_W-1:0];
            REG_MAX_SPEED:    max_speed_in = csr_chan.data[CFG_W-1:0];
            default: begin
               // unknown index: drop
            end
         endcase
      end
   end

   // tick sequencer
   always_comb begin
      state_in     = state_ff;
      last_time_in = last_time_ff;
      elapsed_in   = elapsed_ff;
      goal_vel_in  = goal_vel_ff;
      goal_rot_in  = goal_rot_ff;
      corr_in      = corr_ff;
      cur_vel_in   = cur_vel_ff;
      cur_rot_in   = cur_rot_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         T_IDLE: begin
            if (req_xfer) begin
               elapsed_in   = req_chan.now_us - last_time_ff;
               last_time_in = req_chan.now_us;
               goal_vel_in  = req_chan.goal_velocity;
               goal_rot_in  = req_chan.goal_rotation;
               corr_in      = req_chan.correction;
               state_in     = (accel_ff == '0) ? T_MOVE : T_START;
            end
         end
         T_START: begin
            state_in = T_WAIT;
         end
         T_WAIT: begin
            if (step_done) state_in = T_MOVE;
         end
         T_MOVE: begin
            if (accel_ff == '0) begin
               cur_vel_in = goal_vel_ff;
               cur_rot_in = goal_rot_ff;
            end else begin
               cur_vel_in = approach(cur_vel_ff, goal_vel_ff, step);
               cur_rot_in = approach(cur_rot_ff, goal_rot_ff, step);
            end
            state_in = T_OUT;
         end
         T_OUT: begin
            // hold until the result register can take the mix
            if (out_free) begin
               left_in      = clamp(mix_left, max_speed_ff);
               right_in     = clamp(mix_right, max_speed_ff);
               rsp_valid_in = 1'b1;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         accel_ff     <= '0;
         max_speed_ff <= '0;
         last_time_ff <= '0;
         cur_vel_ff   <= '0;
         cur_rot_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         accel_ff     <= accel_in;
         max_speed_ff <= max_speed_in;
         last_time_ff <= last_time_in;
         cur_vel_ff   <= cur_vel_in;
         cur_rot_ff   <= cur_rot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      elapsed_ff  <= elapsed_in;
      goal_vel_ff <= goal_vel_in;
      goal_rot_ff <= goal_rot_in;
      corr_ff     <= corr_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.left_drive  = left_ff;
   assign rsp_chan.right_drive = right_ff;

endmodule : diff_drive_ramp_mixer_top

`default_nettype wire
